>>> rtl/dor_pkg.sv
// dor_pkg: shared types, codes and widths for the disc obstacle rasterizer
// no dependencies; imported by every rtl module of the block
`default_nettype none

package dor_pkg;

  localparam int unsigned MAP_W     = 64;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned CTR_W     = 12;
  localparam int unsigned RAD_IN_W  = 10;
  localparam int unsigned ROW_SEL_W = 6;
  localparam int unsigned COORD_W   = 18;
  localparam int unsigned RQ_W      = 14;
  localparam int unsigned ROOT_W    = 14;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 4;
  localparam int unsigned CNT_W     = $clog2(ROOT_W);
  localparam int unsigned ROW_MAX_W = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RSQ,
    S_ROW,
    S_ROOT_LD,
    S_ROOT,
    S_WRITE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic signed [CTR_W-1:0]     center_x;
    logic signed [CTR_W-1:0]     center_y;
    logic [RAD_IN_W-1:0]         disc_radius;
    logic [ROW_SEL_W-1:0]        row_select;
  } in_word_t;

  typedef struct packed {
    logic [MAP_W-1:0]     row_bits;
    logic [ROW_SEL_W-1:0] row_echo;
  } out_word_t;

  typedef struct packed {
    logic                 clear;
    logic                 rd_en;
    logic                 wr_en;
    logic [ROW_MAX_W-1:0] rd_addr;
    logic [ROW_MAX_W-1:0] wr_addr;
  } map_req_t;

endpackage

`default_nettype wire

>>> rtl/disc_obstacle_rasterizer_top.sv
// disc_obstacle_rasterizer_top: sequencer, shared squarer and output register
// depends on dor_pkg, dor_isqrt, dor_span_mask, dor_map_mem
`default_nettype none

// Occupancy grid of GRID_HEIGHT rows by GRID_WIDTH cells with one command word
// at a time: clear, add disc, read row. Every command returns one word. An add
// disc first squares the radius, then tests each grid row in turn; each row the
// disc covers adds a root load and row read, the 14 iterations of the shared
// root unit and the row write. in_ready_o is low while a command is in
// progress or while its result waits for a previous word still held in the
// output register.
module disc_obstacle_rasterizer_top import dor_pkg::*; #(
  parameter int unsigned GRID_WIDTH     = 64,
  parameter int unsigned GRID_HEIGHT    = 64,
  parameter int unsigned CELLS_PER_UNIT = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  localparam int unsigned RW = $clog2(GRID_HEIGHT);
  localparam logic signed [COORD_W-1:0] Cpu  = COORD_W'(CELLS_PER_UNIT);
  localparam logic signed [COORD_W-1:0] XOff = COORD_W'(GRID_WIDTH * 8);
  localparam logic signed [COORD_W-1:0] YOff = COORD_W'(GRID_HEIGHT * 8);
  localparam logic [RW-1:0]             JLast = RW'(GRID_HEIGHT - 1);

  state_e                    state_q, state_d;
  cmd_e                      cmd_q, cmd_d;
  logic signed [COORD_W-1:0] cx_q, cx_d;
  logic signed [COORD_W-1:0] cy_q, cy_d;
  logic [RQ_W-1:0]           rq_q, rq_d;
  logic [RAD_W-1:0]          r2_q, r2_d;
  logic [RAD_W-1:0]          dysq_q, dysq_d;
  logic [RW-1:0]             j_q, j_d;
  logic [ROW_SEL_W-1:0]      scan_row_q, scan_row_d;
  logic                      in_range_q, in_range_d;
  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_word_q, out_word_d;

  logic                      accept;
  logic signed [COORD_W-1:0] cx_ext;
  logic signed [COORD_W-1:0] cy_ext;
  logic signed [COORD_W-1:0] jq4;
  logic signed [COORD_W-1:0] dy;
  logic signed [COORD_W-1:0] dy_abs;
  logic signed [COORD_W-1:0] rq_s;
  logic                      in_row;
  logic [RQ_W-1:0]           sq_op;
  logic [RAD_W-1:0]          sq_prod;

  map_req_t                  map_req;
  logic [MAP_W-1:0]          map_rd_data;
  logic [MAP_W-1:0]          span;
  logic                      root_start;
  logic                      root_busy;
  logic [ROOT_W-1:0]         root;

  dor_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (r2_q - dysq_q),
    .busy_o     (root_busy),
    .root_o     (root)
  );

  dor_span_mask #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_span_mask (
    .cx_i   (cx_q),
    .rq_i   (rq_q),
    .root_i (root),
    .mask_o (span)
  );

  dor_map_mem #(
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .wr_data_i (map_rd_data | span),
    .rd_data_o (map_rd_data)
  );

  assign accept = in_valid_i && in_ready_o;
  assign cx_ext = {{(COORD_W-CTR_W){in_word_i.center_x[CTR_W-1]}}, in_word_i.center_x};
  assign cy_ext = {{(COORD_W-CTR_W){in_word_i.center_y[CTR_W-1]}}, in_word_i.center_y};

  // row test and the one shared squarer
  always_comb begin
    jq4     = COORD_W'({j_q, 4'b0000});
    dy      = jq4 - cy_q;
    rq_s    = COORD_W'(rq_q);
    in_row  = (dy >= -rq_s) && (dy < rq_s);
    dy_abs  = (dy < 0) ? -dy : dy;
    sq_op   = (state_q == S_RSQ) ? rq_q : dy_abs[RQ_W-1:0];
    sq_prod = RAD_W'(sq_op) * RAD_W'(sq_op);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    rq_d        = rq_q;
    r2_d        = r2_q;
    dysq_d      = dysq_q;
    j_d         = j_q;
    scan_row_d  = scan_row_q;
    in_range_d  = in_range_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    in_ready_o  = 1'b0;
    root_start  = 1'b0;
    map_req     = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = cmd_e'(in_word_i.cmd);
          state_d = S_FINISH;
          case (cmd_e'(in_word_i.cmd))
            CMD_CLEAR: begin
              map_req.clear = 1'b1;
            end
            CMD_ADD: begin
              cx_d    = cx_ext * Cpu + XOff;
              cy_d    = cy_ext * Cpu + YOff;
              rq_d    = RQ_W'(in_word_i.disc_radius) * RQ_W'(CELLS_PER_UNIT);
              j_d     = '0;
              state_d = S_RSQ;
            end
            CMD_READ: begin
              scan_row_d      = in_word_i.row_select;
              in_range_d      = {3'b000, in_word_i.row_select} < 9'(GRID_HEIGHT);
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = ROW_MAX_W'(in_word_i.row_select);
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_RSQ: begin
        r2_d    = sq_prod;
        state_d = S_ROW;
      end
      S_ROW: begin
        if (in_row) begin
          dysq_d  = sq_prod;
          state_d = S_ROOT_LD;
        end else if (j_q == JLast) begin
          state_d = S_FINISH;
        end else begin
          j_d = j_q + RW'(1);
        end
      end
      S_ROOT_LD: begin
        root_start      = 1'b1;
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = ROW_MAX_W'(j_q);
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        if (!root_busy) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = ROW_MAX_W'(j_q);
        if (j_q == JLast) begin
          state_d = S_FINISH;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_ROW;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_word_d.row_echo = scan_row_q;
          out_word_d.row_bits = (cmd_q == CMD_READ && in_range_q) ? map_rd_data : '0;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_row_q  <= '0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      scan_row_q  <= scan_row_d;
      out_valid_q <= out_valid_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    rq_q       <= rq_d;
    r2_q       <= r2_d;
    dysq_q     <= dysq_d;
    in_range_q <= in_range_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted word did not start a command");

  a_root_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_busy |-> state_q == S_ROOT)
    else $error("root unit busy outside its wait state");

  a_write_only_for_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> cmd_q == CMD_ADD && !root_busy)
    else $error("row write outside a disc command");
`endif

endmodule

`default_nettype wire

>>> rtl/dor_isqrt.sv
// dor_isqrt: iterative integer square root, one result bit per cycle
// depends on dor_pkg
`default_nettype none

module dor_isqrt import dor_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  radicand_i,
  output logic                   busy_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> rtl/dor_span_mask.sv
// dor_span_mask: turns a disc chord (center, half width) into a row cell mask
// depends on dor_pkg
`default_nettype none

module dor_span_mask import dor_pkg::*; #(
  parameter int unsigned GRID_WIDTH = 64
) (
  input  wire logic signed [COORD_W-1:0] cx_i,
  input  wire logic [RQ_W-1:0]           rq_i,
  input  wire logic [ROOT_W-1:0]         root_i,
  output logic [MAP_W-1:0]               mask_o
);

  localparam logic signed [COORD_W-1:0] Round = COORD_W'(15);
  localparam logic signed [COORD_W-1:0] One   = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] Zero  = '0;
  localparam logic signed [COORD_W-1:0] XMax  = COORD_W'(GRID_WIDTH - 1);
  localparam logic [MAP_W-1:0]          Ones  = '1;

  logic signed [COORD_W-1:0] s_s;
  logic signed [COORD_W-1:0] rq_s;
  logic signed [COORD_W-1:0] lim;
  logic signed [COORD_W-1:0] lo_q4;
  logic signed [COORD_W-1:0] hi_q4;
  logic signed [COORD_W-1:0] lo_cell;
  logic signed [COORD_W-1:0] hi_cell;
  logic [CELL_W-1:0]         lo_sh;
  logic [CELL_W-1:0]         hi_top;
  logic                      empty;

  always_comb begin
    s_s     = COORD_W'(root_i);
    rq_s    = COORD_W'(rq_i);
    // strict right edge only bites on the center row
    lim     = (root_i == rq_i) ? (rq_s - One) : s_s;
    lo_q4   = cx_i - s_s + Round;
    hi_q4   = cx_i + lim;
    lo_cell = lo_q4 >>> 4;
    hi_cell = hi_q4 >>> 4;
    empty   = (lo_cell > XMax) || (hi_cell < Zero) || (lo_cell > hi_cell);
    lo_sh   = (lo_cell < Zero) ? '0 : lo_cell[CELL_W-1:0];
    hi_top  = (hi_cell > XMax) ? XMax[CELL_W-1:0] : hi_cell[CELL_W-1:0];
    mask_o  = empty ? '0 : ((Ones << lo_sh) & (Ones >> (CELL_W'(MAP_W - 1) - hi_top)));
  end

endmodule

`default_nettype wire

>>> rtl/dor_map_mem.sv
// dor_map_mem: occupancy row memory with per-row valid bits so that a clear resets every row at once
// depends on dor_pkg
`default_nettype none

module dor_map_mem import dor_pkg::*; #(
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire map_req_t         req_i,
  input  wire logic [MAP_W-1:0] wr_data_i,
  output logic [MAP_W-1:0]      rd_data_o
);

  localparam int unsigned RW = $clog2(GRID_HEIGHT);

  logic [MAP_W-1:0]       mem_q [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] valid_q;
  logic [MAP_W-1:0]       rd_data_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr[RW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[RW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr[RW-1:0]];
      rd_vld_q  <= valid_q[req_i.rd_addr[RW-1:0]];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire
